[design/sltc_pkg.sv]
`default_nettype none

package sltc_pkg;

  // Default sizing of the table.
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the words.
  localparam int unsigned OP_W          = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_OUT_W   = 7;

  // Requested operation, carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  // Result status code.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Command broadcast to every cell in the cycle a word is accepted.
  typedef struct packed {
    logic ins;  // insert the value at its ordered place
    logic del;  // remove the first entry equal to the value
  } sltc_cmd_t;

endpackage

`default_nettype wire

[design/sltc_cell.sv]
`default_nettype none

module sltc_cell
  import sltc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sltc_cmd_t             cmd_i,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  // Left neighbor (smaller entries).
  input  wire logic                  left_valid_i,
  input  wire logic [DATA_WIDTH-1:0] left_data_i,
  input  wire logic                  left_pos_i,
  // Right neighbor (larger entries).
  input  wire logic                  right_valid_i,
  input  wire logic [DATA_WIDTH-1:0] right_data_i,
  // Own state and compare results.
  output logic                       valid_o,
  output logic [DATA_WIDTH-1:0]      data_o,
  output logic                       pos_o,
  output logic                       eq_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  gt, ge;

  // Local signed compares against the broadcast value.
  assign gt    = valid_q && ($signed(data_q) >  $signed(value_i));
  assign ge    = valid_q && ($signed(data_q) >= $signed(value_i));
  assign eq_o  = valid_q && (data_q == value_i);
  // This cell sits at or right of the insertion point.
  assign pos_o = gt || !valid_q;

  // Insert shifts right from the insertion point; delete shifts left from the first match.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.ins && pos_o) begin
      valid_d = valid_q || left_valid_i;
      data_d  = left_pos_i ? left_data_i : value_i;
    end else if (cmd_i.del && (ge || !valid_q)) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[design/sorted_list_table_core.sv]
`default_nettype none

// Sorted table of up to CAPACITY signed values, duplicates allowed.
// Input channel (s_axis): tuser carries the operation (insert, delete one
// occurrence, search) and tdata the value. Output channel (m_axis): one word
// per input word with status, found flag, entry count, smallest and largest
// stored value and an empty flag.
// Each entry lives in a cell of a chain; an accepted word is compared in all
// cells in the same cycle and every cell takes its own entry, its left or its
// right neighbor's entry or the new value, so the whole table updates at once.
// The result word is registered first in the cells and then in the output
// register that reads the first and last valid cell. A new word is accepted
// once the previous result has been registered and is taken or being taken.
// Reset empties the table at once; no clearing pass is needed.
// When the receiver stalls, the result word holds and s_axis_tready stays
// low until it is taken.
module sorted_list_table_core
  import sltc_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W = STATUS_W + 1 + COUNT_OUT_W + 2 * DATA_WIDTH + 1,
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // value
  input  wire logic [OP_W-1:0]  s_axis_tuser,  // operation
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // status, found, entry_count, smallest, largest, is_empty
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] value;
  op_e                   op;
  logic                  in_acc;
  logic                  full;
  logic                  any_eq;
  sltc_cmd_t             cmd;

  logic [CAPACITY-1:0]   cell_valid;
  logic [CAPACITY-1:0]   cell_pos;
  logic [CAPACITY-1:0]   cell_eq;
  logic [CAPACITY-1:0]   cell_last;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  pend_q;
  status_e               pend_status_q, pend_status_d;
  logic                  pend_found_q, pend_found_d;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic                  out_found_q;
  logic [COUNT_OUT_W-1:0] out_count_q;
  logic [DATA_WIDTH-1:0] out_small_q, out_large_q, largest;
  logic                  out_empty_q;

  assign value  = s_axis_tdata[DATA_WIDTH-1:0];
  assign op     = op_e'(s_axis_tuser);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign full   = cell_valid[CAPACITY-1];
  assign any_eq = |cell_eq;

  assign s_axis_tready = !pend_q && (!out_valid_q || m_axis_tready);

  // Decode the accepted word into the cell command and the result flags.
  always_comb begin
    cmd           = '0;
    count_d       = count_q;
    pend_status_d = ST_DONE;
    pend_found_d  = 1'b0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          pend_status_d = ST_FULL;
        end else begin
          cmd.ins = in_acc;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        pend_found_d = any_eq;
        if (any_eq) begin
          cmd.del = in_acc;
          count_d = count_q - CNT_W'(1);
        end else begin
          pend_status_d = ST_ABSENT;
        end
      end
      OP_SEARCH: begin
        pend_found_d = any_eq;
      end
      default: begin
        pend_status_d = ST_DONE;
      end
    endcase
  end

  // Chain of cells, smallest entry in cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_valid, l_pos, r_valid;
    logic [DATA_WIDTH-1:0] l_data, r_data;
    if (i == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_pos   = 1'b0;
      assign l_data  = '0;
    end else begin : g_inner_l
      assign l_valid = cell_valid[i-1];
      assign l_pos   = cell_pos[i-1];
      assign l_data  = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_valid      = 1'b0;
      assign r_data       = '0;
      assign cell_last[i] = cell_valid[i];
    end else begin : g_inner_r
      assign r_valid      = cell_valid[i+1];
      assign r_data       = cell_data[i+1];
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end
    sltc_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .value_i      (value),
      .left_valid_i (l_valid),
      .left_data_i  (l_data),
      .left_pos_i   (l_pos),
      .right_valid_i(r_valid),
      .right_data_i (r_data),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i]),
      .pos_o        (cell_pos[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // The last valid cell holds the largest entry; at most one cell is marked.
  always_comb begin
    largest = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      largest = largest | (cell_data[k] & {DATA_WIDTH{cell_last[k]}});
    end
  end

  // Count and pending result of the word in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= in_acc;
      if (in_acc) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_status_q <= pend_status_d;
      pend_found_q  <= pend_found_d;
    end
  end

  // Output register, loaded from the updated table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_status_q <= pend_status_q;
      out_found_q  <= pend_found_q;
      out_count_q  <= COUNT_OUT_W'(count_q);
      out_small_q  <= cell_valid[0] ? cell_data[0] : '0;
      out_large_q  <= largest;
      out_empty_q  <= !cell_valid[0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_empty_q, out_large_q, out_small_q,
                                 out_count_q, out_found_q, out_status_q});

`ifndef SYNTHESIS
  // The count always matches the number of occupied cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(cell_valid)) == count_q)
    else $error("entry count differs from occupied cells");

  // Occupied cells form one run starting at cell 0.
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in occupied cells");

  // A pending result never meets a held output word.
  a_pend_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("result pending while output word is held");

  // An insert into a full table leaves the count unchanged.
  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OP_INSERT) && full) |=> $stable(count_q))
    else $error("insert into full table changed the count");
`endif

endmodule

`default_nettype wire
